// File: sv/euler_rotation_about_pivot_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Euler rotation core
// Shared forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATION_ABOUT_PIVOT_CORE_ASSERT_SVH
`define EULER_ROTATION_ABOUT_PIVOT_CORE_ASSERT_SVH

// same-cycle implication
`define ERAP_AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ERAP_AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/erap_pkg.sv
// ----------------------------------------------------------------------------
// erap_pkg
// Widths, register indexes and shared types of the Euler rotation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package erap_pkg;

    localparam int CW     = 32;          // coordinate width
    localparam int DW     = CW + 1;      // value minus pivot
    localparam int TRIG_W = 16;          // Q1.14 sine / cosine
    localparam int ANG_W  = 16;          // Q3.12 angle
    localparam int PW     = DW + TRIG_W; // one product
    localparam int SW     = PW + 1;      // sum of two products
    localparam int QW     = SW - 14;     // sum after the shift
    localparam int NW     = QW + 1;      // plus pivot, before saturation
    localparam int NUM_AX = 3;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        IDX_ANG_X = 3'd0,
        IDX_ANG_Y = 3'd1,
        IDX_ANG_Z = 3'd2,
        IDX_PIV_X = 3'd3,
        IDX_PIV_Y = 3'd4,
        IDX_PIV_Z = 3'd5
    } t_cfg_idx;

    typedef logic signed [CW-1:0]     t_coord;
    typedef logic signed [TRIG_W-1:0] t_trig_val;

    typedef struct packed {
        t_trig_val cos_v;
        t_trig_val sin_v;
        logic      rot;
    } t_axis_trig;

    typedef struct packed {
        t_axis_trig [NUM_AX-1:0] ax;
        logic                    busy;
    } t_trig_st;

    // a, b turn; c passes
    typedef struct packed {
        t_coord pa;
        t_coord pb;
        t_coord pc;
        t_coord na;
        t_coord nb;
        t_coord nc;
    } t_vtx;

endpackage

`default_nettype wire

// File: sv/erap_trig.sv
// ----------------------------------------------------------------------------
// erap_trig
// Angle registers and sine/cosine table, refilled by an iterative CORDIC
// unit (one micro-rotation per cycle) after each angle write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module erap_trig (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [erap_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [erap_pkg::CW-1:0]       i_cfg_data,
    output erap_pkg::t_trig_st                 o_trig
);

    localparam int TW    = 26;
    localparam int XW    = 34;
    localparam int IW    = 5;
    localparam int STEPS = 20;
    localparam int RW    = XW - 16;
    localparam int NRW   = RW + 1;

    localparam logic signed [TW-1:0] PI_Q20      = TW'(3294199);
    localparam logic signed [TW-1:0] TWO_PI_Q20  = TW'(6588397);
    localparam logic signed [TW-1:0] HALF_PI_Q20 = TW'(1647099);
    localparam logic signed [XW-1:0] GAIN_Q30    = XW'(652032874);
    localparam logic signed [XW-1:0] ROUND_HALF  = XW'(32768);
    localparam logic signed [NRW-1:0] ONE_Q14    = NRW'(16384);
    localparam logic [IW-1:0]        LAST_STEP   = IW'(STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ITER,
        ST_DONE
    } t_state;

    function automatic logic signed [TW-1:0] atan_q20(input logic [IW-1:0] idx);
        logic signed [TW-1:0] v;
        unique case (idx)
            5'd0:    v = TW'(823550);
            5'd1:    v = TW'(486170);
            5'd2:    v = TW'(256879);
            5'd3:    v = TW'(130396);
            5'd4:    v = TW'(65451);
            5'd5:    v = TW'(32757);
            5'd6:    v = TW'(16383);
            5'd7:    v = TW'(8192);
            5'd8:    v = TW'(4096);
            5'd9:    v = TW'(2048);
            5'd10:   v = TW'(1024);
            5'd11:   v = TW'(512);
            5'd12:   v = TW'(256);
            5'd13:   v = TW'(128);
            5'd14:   v = TW'(64);
            5'd15:   v = TW'(32);
            5'd16:   v = TW'(16);
            5'd17:   v = TW'(8);
            5'd18:   v = TW'(4);
            5'd19:   v = TW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic erap_pkg::t_trig_val clamp_q14(input logic signed [NRW-1:0] v);
        logic signed [NRW-1:0] c;
        if (v > ONE_Q14) begin
            c = ONE_Q14;
        end else if (v < -ONE_Q14) begin
            c = -ONE_Q14;
        end else begin
            c = v;
        end
        return c[erap_pkg::TRIG_W-1:0];
    endfunction

    t_state                         r_state;
    logic [1:0]                     r_ax;
    logic [IW-1:0]                  r_i;
    logic signed [TW-1:0]           r_t;
    logic signed [XW-1:0]           r_x;
    logic signed [XW-1:0]           r_y;
    logic                           r_neg;
    logic [erap_pkg::NUM_AX-1:0]    r_pend;
    logic signed [erap_pkg::ANG_W-1:0] r_ang [erap_pkg::NUM_AX];
    erap_pkg::t_trig_val            r_cos [erap_pkg::NUM_AX];
    erap_pkg::t_trig_val            r_sin [erap_pkg::NUM_AX];

    logic [erap_pkg::NUM_AX-1:0]    w_wr;
    logic [erap_pkg::NUM_AX-1:0]    w_clr;
    logic [1:0]                     w_pick;
    logic signed [TW-1:0]           w_t0;
    logic signed [TW-1:0]           w_t1;
    logic signed [TW-1:0]           w_t2;
    logic                           w_neg2;
    logic signed [XW-1:0]           w_dx;
    logic signed [XW-1:0]           w_dy;
    logic signed [XW-1:0]           w_xr;
    logic signed [XW-1:0]           w_yr;
    logic signed [RW-1:0]           w_cq;
    logic signed [RW-1:0]           w_sq;
    logic signed [NRW-1:0]          w_cn;
    logic signed [NRW-1:0]          w_sn;

    always_comb begin
        w_wr[0] = i_cfg_we && (i_cfg_idx == erap_pkg::IDX_ANG_X);
        w_wr[1] = i_cfg_we && (i_cfg_idx == erap_pkg::IDX_ANG_Y);
        w_wr[2] = i_cfg_we && (i_cfg_idx == erap_pkg::IDX_ANG_Z);

        priority if (r_pend[0]) begin
            w_pick = 2'd0;
        end else if (r_pend[1]) begin
            w_pick = 2'd1;
        end else begin
            w_pick = 2'd2;
        end

        w_clr = '0;
        if (r_state == ST_IDLE && r_pend != '0) begin
            w_clr[w_pick] = 1'b1;
        end

        // first fold into [-pi, pi]
        w_t0 = TW'(r_ang[w_pick]) <<< 8;
        if (w_t0 > PI_Q20) begin
            w_t1 = w_t0 - TWO_PI_Q20;
        end else if (w_t0 < -PI_Q20) begin
            w_t1 = w_t0 + TWO_PI_Q20;
        end else begin
            w_t1 = w_t0;
        end

        // second fold into [-pi/2, pi/2]
        w_neg2 = 1'b1;
        if (r_t > HALF_PI_Q20) begin
            w_t2 = r_t - PI_Q20;
        end else if (r_t < -HALF_PI_Q20) begin
            w_t2 = r_t + PI_Q20;
        end else begin
            w_t2   = r_t;
            w_neg2 = 1'b0;
        end

        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;

        w_xr = r_x + ROUND_HALF;
        w_yr = r_y + ROUND_HALF;
        w_cq = w_xr[XW-1:16];
        w_sq = w_yr[XW-1:16];
        w_cn = r_neg ? -NRW'(w_cq) : NRW'(w_cq);
        w_sn = r_neg ? -NRW'(w_sq) : NRW'(w_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_ax    <= '0;
            r_i     <= '0;
            r_neg   <= 1'b0;
            for (int k = 0; k < erap_pkg::NUM_AX; k++) begin
                r_ang[k] <= '0;
                r_cos[k] <= erap_pkg::TRIG_W'(16384);
                r_sin[k] <= '0;
            end
        end else begin
            r_pend <= (r_pend & ~w_clr) | w_wr;
            for (int k = 0; k < erap_pkg::NUM_AX; k++) begin
                if (w_wr[k]) begin
                    r_ang[k] <= i_cfg_data[erap_pkg::ANG_W-1:0];
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (r_pend != '0) begin
                        r_ax    <= w_pick;
                        r_t     <= w_t1;
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    r_t     <= w_t2;
                    r_neg   <= w_neg2;
                    r_x     <= GAIN_Q30;
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= ST_ITER;
                end
                ST_ITER: begin
                    if (!r_t[TW-1]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_t <= r_t - atan_q20(r_i);
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_t <= r_t + atan_q20(r_i);
                    end
                    r_i <= r_i + IW'(1);
                    if (r_i == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_cos[r_ax] <= clamp_q14(w_cn);
                    r_sin[r_ax] <= clamp_q14(w_sn);
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < erap_pkg::NUM_AX; k++) begin
            o_trig.ax[k].cos_v = r_cos[k];
            o_trig.ax[k].sin_v = r_sin[k];
            o_trig.ax[k].rot   = (r_ang[k] != '0);
        end
        o_trig.busy = (r_state != ST_IDLE) || (r_pend != '0) || (w_wr != '0);
    end

endmodule

`default_nettype wire

// File: sv/erap_axis.sv
// ----------------------------------------------------------------------------
// erap_axis
// Four-stage rotation of position (about a pivot) and normal (about the
// origin) in one coordinate plane; the third coordinate rides along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module erap_axis (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  erap_pkg::t_axis_trig      i_trig,
    input  erap_pkg::t_coord          i_piv_a,
    input  erap_pkg::t_coord          i_piv_b,
    input  erap_pkg::t_vtx            i_v,
    output logic                      o_vld,
    output erap_pkg::t_vtx            o_v
);

    localparam int DW = erap_pkg::DW;
    localparam int PW = erap_pkg::PW;
    localparam int SW = erap_pkg::SW;
    localparam int QW = erap_pkg::QW;
    localparam int NW = erap_pkg::NW;
    localparam int CW = erap_pkg::CW;

    localparam erap_pkg::t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam erap_pkg::t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    function automatic erap_pkg::t_coord sat_coord(input logic signed [NW-1:0] v);
        logic signed [NW-1:0] c;
        if (v > NW'(COORD_MAX)) begin
            c = NW'(COORD_MAX);
        end else if (v < NW'(COORD_MIN)) begin
            c = NW'(COORD_MIN);
        end else begin
            c = v;
        end
        return c[CW-1:0];
    endfunction

    logic [3:0]              r_vld;

    logic signed [DW-1:0]    r1_dpa, r1_dpb, r1_dna, r1_dnb;
    erap_pkg::t_vtx          r1_v;

    logic signed [PW-1:0]    r2_pac, r2_pbs, r2_pas, r2_pbc;
    logic signed [PW-1:0]    r2_nac, r2_nbs, r2_nas, r2_nbc;
    erap_pkg::t_vtx          r2_v;

    logic signed [QW-1:0]    r3_pa, r3_pb, r3_na, r3_nb;
    erap_pkg::t_vtx          r3_v;

    erap_pkg::t_vtx          r4_v;

    logic signed [SW-1:0]    w_spa, w_spb, w_sna, w_snb;
    logic signed [NW-1:0]    w_npa, w_npb;
    erap_pkg::t_vtx          n_v;

    always_comb begin
        w_spa = SW'(r2_pac) - SW'(r2_pbs);
        w_spb = SW'(r2_pas) + SW'(r2_pbc);
        w_sna = SW'(r2_nac) - SW'(r2_nbs);
        w_snb = SW'(r2_nas) + SW'(r2_nbc);

        w_npa = NW'(r3_pa) + NW'(i_piv_a);
        w_npb = NW'(r3_pb) + NW'(i_piv_b);

        n_v = r3_v;
        if (i_trig.rot) begin
            n_v.pa = sat_coord(w_npa);
            n_v.pb = sat_coord(w_npb);
            n_v.na = sat_coord(NW'(r3_na));
            n_v.nb = sat_coord(NW'(r3_nb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dpa <= DW'(i_v.pa) - DW'(i_piv_a);
            r1_dpb <= DW'(i_v.pb) - DW'(i_piv_b);
            r1_dna <= DW'(i_v.na);
            r1_dnb <= DW'(i_v.nb);
            r1_v   <= i_v;

            r2_pac <= r1_dpa * i_trig.cos_v;
            r2_pbs <= r1_dpb * i_trig.sin_v;
            r2_pas <= r1_dpa * i_trig.sin_v;
            r2_pbc <= r1_dpb * i_trig.cos_v;
            r2_nac <= r1_dna * i_trig.cos_v;
            r2_nbs <= r1_dnb * i_trig.sin_v;
            r2_nas <= r1_dna * i_trig.sin_v;
            r2_nbc <= r1_dnb * i_trig.cos_v;
            r2_v   <= r1_v;

            r3_pa  <= w_spa[SW-1:14];
            r3_pb  <= w_spb[SW-1:14];
            r3_na  <= w_sna[SW-1:14];
            r3_nb  <= w_snb[SW-1:14];
            r3_v   <= r2_v;

            r4_v   <= n_v;
        end
    end

    assign o_vld = r_vld[3];
    assign o_v   = r4_v;

endmodule

`default_nettype wire

// File: sv/euler_rotation_about_pivot_core.sv
// ----------------------------------------------------------------------------
// euler_rotation_about_pivot_core
// Rotates a vertex position about a pivot and its normal about the origin,
// in turn about x, y and z, with saturation after each axis.
//
//   channel   direction  handshake                 beat
//   input     in         i_in_valid / o_in_stall   i_pos_*, i_norm_*
//   output    out        o_out_valid / i_out_stall o_rot_pos_*, o_rot_norm_*
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One beat per cycle when not stalled; three axis units of four stages.
// Each angle write refills its sine/cosine entry in order: pick, fold,
// 20 CORDIC iterations (one per cycle) and write-back; input stalls until
// all pending entries are done. A stall on a valid output freezes
// the whole pipeline. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module euler_rotation_about_pivot_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [erap_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [erap_pkg::CW-1:0]     i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire erap_pkg::t_coord            i_pos_x,
    input  wire erap_pkg::t_coord            i_pos_y,
    input  wire erap_pkg::t_coord            i_pos_z,
    input  wire erap_pkg::t_coord            i_norm_x,
    input  wire erap_pkg::t_coord            i_norm_y,
    input  wire erap_pkg::t_coord            i_norm_z,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output erap_pkg::t_coord                 o_rot_pos_x,
    output erap_pkg::t_coord                 o_rot_pos_y,
    output erap_pkg::t_coord                 o_rot_pos_z,
    output erap_pkg::t_coord                 o_rot_norm_x,
    output erap_pkg::t_coord                 o_rot_norm_y,
    output erap_pkg::t_coord                 o_rot_norm_z
);

    erap_pkg::t_coord    r_piv_x, r_piv_y, r_piv_z;
    erap_pkg::t_trig_st  w_trig;
    logic                w_en, w_acc;
    logic                w_vld_x, w_vld_y, w_vld_z;
    erap_pkg::t_vtx      w_in, w_vx, w_iy, w_vy, w_iz, w_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piv_x <= '0;
            r_piv_y <= '0;
            r_piv_z <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == erap_pkg::IDX_PIV_X) begin
                r_piv_x <= i_cfg_data;
            end
            if (i_cfg_idx == erap_pkg::IDX_PIV_Y) begin
                r_piv_y <= i_cfg_data;
            end
            if (i_cfg_idx == erap_pkg::IDX_PIV_Z) begin
                r_piv_z <= i_cfg_data;
            end
        end
    end

    erap_trig u_trig (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_trig     (w_trig)
    );

    assign w_en       = !w_vld_z || !i_out_stall;
    assign o_in_stall = !i_rst_n || !w_en || w_trig.busy;
    assign w_acc      = i_in_valid && !o_in_stall;

    // x axis turns (y, z)
    always_comb begin
        w_in.pa = i_pos_y;
        w_in.pb = i_pos_z;
        w_in.pc = i_pos_x;
        w_in.na = i_norm_y;
        w_in.nb = i_norm_z;
        w_in.nc = i_norm_x;
    end

    erap_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_acc),
        .i_trig  (w_trig.ax[0]),
        .i_piv_a (r_piv_y),
        .i_piv_b (r_piv_z),
        .i_v     (w_in),
        .o_vld   (w_vld_x),
        .o_v     (w_vx)
    );

    // y axis turns (z, x)
    always_comb begin
        w_iy.pa = w_vx.pb;
        w_iy.pb = w_vx.pc;
        w_iy.pc = w_vx.pa;
        w_iy.na = w_vx.nb;
        w_iy.nb = w_vx.nc;
        w_iy.nc = w_vx.na;
    end

    erap_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_x),
        .i_trig  (w_trig.ax[1]),
        .i_piv_a (r_piv_z),
        .i_piv_b (r_piv_x),
        .i_v     (w_iy),
        .o_vld   (w_vld_y),
        .o_v     (w_vy)
    );

    // z axis turns (x, y)
    always_comb begin
        w_iz.pa = w_vy.pb;
        w_iz.pb = w_vy.pc;
        w_iz.pc = w_vy.pa;
        w_iz.na = w_vy.nb;
        w_iz.nb = w_vy.nc;
        w_iz.nc = w_vy.na;
    end

    erap_axis u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_y),
        .i_trig  (w_trig.ax[2]),
        .i_piv_a (r_piv_x),
        .i_piv_b (r_piv_y),
        .i_v     (w_iz),
        .o_vld   (w_vld_z),
        .o_v     (w_vz)
    );

    assign o_out_valid  = w_vld_z;
    assign o_rot_pos_x  = w_vz.pa;
    assign o_rot_pos_y  = w_vz.pb;
    assign o_rot_pos_z  = w_vz.pc;
    assign o_rot_norm_x = w_vz.na;
    assign o_rot_norm_y = w_vz.nb;
    assign o_rot_norm_z = w_vz.nc;

endmodule

`default_nettype wire

// File: sv/erap_checker.sv
// ----------------------------------------------------------------------------
// erap_checker
// Port-level checks of the Euler rotation core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "euler_rotation_about_pivot_core_assert.svh"

module erap_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [erap_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic                        o_in_stall,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_stall,
    input  wire erap_pkg::t_coord            o_rot_pos_x,
    input  wire erap_pkg::t_coord            o_rot_pos_y,
    input  wire erap_pkg::t_coord            o_rot_pos_z,
    input  wire erap_pkg::t_coord            o_rot_norm_x,
    input  wire erap_pkg::t_coord            o_rot_norm_y,
    input  wire erap_pkg::t_coord            o_rot_norm_z
);

    logic                        w_held;
    logic                        w_ang_wr;
    logic [6*erap_pkg::CW-1:0]   w_out_bus;

    assign w_held    = o_out_valid && i_out_stall;
    assign w_ang_wr  = i_cfg_we && (i_cfg_idx == erap_pkg::IDX_ANG_X ||
                                    i_cfg_idx == erap_pkg::IDX_ANG_Y ||
                                    i_cfg_idx == erap_pkg::IDX_ANG_Z);
    assign w_out_bus = {o_rot_pos_x, o_rot_pos_y, o_rot_pos_z,
                        o_rot_norm_x, o_rot_norm_y, o_rot_norm_z};

    `ERAP_AST_NXT(a_out_vld_held, i_clk, i_rst_n, w_held, o_out_valid, "stalled beat dropped")
    `ERAP_AST_NXT(a_out_data_held, i_clk, i_rst_n, w_held, $stable(w_out_bus), "held beat changed")
    `ERAP_AST_IMP(a_backpressure, i_clk, i_rst_n, w_held, o_in_stall, "input taken while frozen")
    `ERAP_AST_IMP(a_wr_blocks_in, i_clk, i_rst_n, w_ang_wr, o_in_stall, "input during angle write")
    `ERAP_AST_NXT(a_trig_refill, i_clk, i_rst_n, w_ang_wr, o_in_stall, "input before trig refill")

endmodule

bind euler_rotation_about_pivot_core erap_checker u_erap_checker (.*);

`default_nettype wire

// File: tb/sv/euler_rotation_about_pivot_core_tb.sv
// ----------------------------------------------------------------------------
// euler_rotation_about_pivot_core_tb
// Drives vertex beats through the rotation core and compares every output
// beat with an in-bench fixed-point predictor (CORDIC sine/cosine, per-axis
// turn about the pivot, saturation). Directed extremes come first, then
// random phases with fresh register settings and random idle/stall bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_rotation_about_pivot_core_tb;

    localparam int CW    = erap_pkg::CW;
    localparam int ANG_W = erap_pkg::ANG_W;
    localparam int IDX_W = erap_pkg::IDX_W;

    typedef erap_pkg::t_coord t_coord;

    localparam int     CYCLE_LIMIT   = 300000;
    localparam int     TAIL_CYCLES   = 40;
    localparam int     PHASES        = 8;
    localparam int     PHASE_BEATS   = 125;
    localparam int     MAX_REPORTS   = 10;
    localparam int     CORDIC_STEPS  = 20;
    localparam longint PI_Q20        = 3294199;
    localparam longint TWO_PI_Q20    = 6588397;
    localparam longint HALF_PI_Q20   = 1647099;
    localparam longint GAIN_Q30      = 652032874;
    localparam longint ONE_Q14       = 16384;
    localparam longint ATAN_Q20 [CORDIC_STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096,
        2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam logic signed [ANG_W-1:0] ANG_MAX     = 16'sh7FFF;
    localparam logic signed [ANG_W-1:0] ANG_MIN     = 16'sh8000;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd6434;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd12868;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 16'sd25736;

    // indexes with no register behind them
    localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
        t_coord norm_x;
        t_coord norm_y;
        t_coord norm_z;
    } t_vertex;

    class vertex_rotation_checker;
        logic signed [ANG_W-1:0] angle [3];
        longint                  pivot [3];
        longint                  cos_q14 [3];
        longint                  sin_q14 [3];
        t_vertex                 rotated_due [$];
        int                      mismatches;

        function new();
            int ax;
            for (ax = 0; ax < 3; ax++) begin
                angle[ax]   = '0;
                pivot[ax]   = 0;
                cos_q14[ax] = ONE_Q14;
                sin_q14[ax] = 0;
            end
            mismatches = 0;
        endfunction

        function void cordic_sin_cos(input logic signed [ANG_W-1:0] ang,
                                     output longint cs, output longint sn);
            longint t, x, y, dx, dy;
            bit     flip;
            int     i;
            t = longint'(ang) * 256;
            x = GAIN_Q30;
            y = 0;
            flip = 1'b0;
            if (t > PI_Q20) t -= TWO_PI_Q20;
            else if (t < -PI_Q20) t += TWO_PI_Q20;
            if (t > HALF_PI_Q20) begin
                t -= PI_Q20;
                flip = 1'b1;
            end else if (t < -HALF_PI_Q20) begin
                t += PI_Q20;
                flip = 1'b1;
            end
            for (i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (t >= 0) begin
                    x -= dx;
                    y += dy;
                    t -= ATAN_Q20[i];
                end else begin
                    x += dx;
                    y -= dy;
                    t += ATAN_Q20[i];
                end
            end
            cs = (x + 32768) >>> 16;
            sn = (y + 32768) >>> 16;
            if (flip) begin
                cs = -cs;
                sn = -sn;
            end
            cs = cs > ONE_Q14 ? ONE_Q14 : (cs < -ONE_Q14 ? -ONE_Q14 : cs);
            sn = sn > ONE_Q14 ? ONE_Q14 : (sn < -ONE_Q14 ? -ONE_Q14 : sn);
        endfunction

        function longint saturate_coord(input longint v);
            longint hi, lo;
            hi = (longint'(1) <<< (CW - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void turn_pair(inout longint a, inout longint b,
                                input longint c, input longint s,
                                input longint pa, input longint pb);
            longint da, db;
            da = a - pa;
            db = b - pb;
            a = saturate_coord(((da * c - db * s) >>> 14) + pa);
            b = saturate_coord(((da * s + db * c) >>> 14) + pb);
        endfunction

        function void write_reg(input logic [IDX_W-1:0] idx, input logic [CW-1:0] data);
            int ax;
            case (idx)
                erap_pkg::IDX_ANG_X, erap_pkg::IDX_ANG_Y, erap_pkg::IDX_ANG_Z: begin
                    ax = int'(idx) - int'(erap_pkg::IDX_ANG_X);
                    angle[ax] = data[ANG_W-1:0];
                    cordic_sin_cos(angle[ax], cos_q14[ax], sin_q14[ax]);
                end
                erap_pkg::IDX_PIV_X, erap_pkg::IDX_PIV_Y, erap_pkg::IDX_PIV_Z: begin
                    ax = int'(idx) - int'(erap_pkg::IDX_PIV_X);
                    pivot[ax] = longint'(t_coord'(data));
                end
                default: ;
            endcase
        endfunction

        function t_vertex rotate_vertex(input t_vertex v);
            longint  p [3];
            longint  n [3];
            int      ax, ia, ib;
            t_vertex r;
            p[0] = v.pos_x;
            p[1] = v.pos_y;
            p[2] = v.pos_z;
            n[0] = v.norm_x;
            n[1] = v.norm_y;
            n[2] = v.norm_z;
            for (ax = 0; ax < 3; ax++) begin
                if (angle[ax] != 0) begin
                    ia = (ax + 1) % 3;
                    ib = (ax + 2) % 3;
                    turn_pair(p[ia], p[ib], cos_q14[ax], sin_q14[ax], pivot[ia], pivot[ib]);
                    turn_pair(n[ia], n[ib], cos_q14[ax], sin_q14[ax], 0, 0);
                end
            end
            r.pos_x  = t_coord'(p[0]);
            r.pos_y  = t_coord'(p[1]);
            r.pos_z  = t_coord'(p[2]);
            r.norm_x = t_coord'(n[0]);
            r.norm_y = t_coord'(n[1]);
            r.norm_z = t_coord'(n[2]);
            return r;
        endfunction

        function void note_vertex(input t_vertex v);
            rotated_due.push_back(rotate_vertex(v));
        endfunction

        function void check_rotated(input t_vertex got);
            string        names [6];
            t_coord [5:0] e_f, g_f;
            t_vertex      want;
            int           f;
            names = '{"norm_z", "norm_y", "norm_x", "pos_z", "pos_y", "pos_x"};
            if (rotated_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected output beat %h", $realtime, got);
                return;
            end
            want = rotated_due.pop_front();
            e_f = want;
            g_f = got;
            for (f = 0; f < 6; f++) begin
                if (e_f[f] !== g_f[f]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] rot_%s: expected %0d (%h) got %0d (%h)", $realtime,
                                 names[f], e_f[f], e_f[f], g_f[f], g_f[f]);
                end
            end
        endfunction

        function int pending();
            return rotated_due.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0]    i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_coord           i_pos_x, i_pos_y, i_pos_z;
    t_coord           i_norm_x, i_norm_y, i_norm_z;
    logic             o_out_valid;
    logic             i_out_stall;
    t_coord           o_rot_pos_x, o_rot_pos_y, o_rot_pos_z;
    t_coord           o_rot_norm_x, o_rot_norm_y, o_rot_norm_z;
    t_vertex          out_beat;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int stall_left   = 0;
    int cycle_cnt    = 0;

    erap_pkg::t_cfg_idx all_regs [6] = '{erap_pkg::IDX_ANG_X, erap_pkg::IDX_ANG_Y,
                                         erap_pkg::IDX_ANG_Z, erap_pkg::IDX_PIV_X,
                                         erap_pkg::IDX_PIV_Y, erap_pkg::IDX_PIV_Z};

    vertex_rotation_checker rot_check = new;

    euler_rotation_about_pivot_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_norm_x     (i_norm_x),
        .i_norm_y     (i_norm_y),
        .i_norm_z     (i_norm_z),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_rot_pos_x  (o_rot_pos_x),
        .o_rot_pos_y  (o_rot_pos_y),
        .o_rot_pos_z  (o_rot_pos_z),
        .o_rot_norm_x (o_rot_norm_x),
        .o_rot_norm_y (o_rot_norm_y),
        .o_rot_norm_z (o_rot_norm_z)
    );

    assign out_beat = {o_rot_pos_x, o_rot_pos_y, o_rot_pos_z,
                       o_rot_norm_x, o_rot_norm_y, o_rot_norm_z};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output stall bursts of random length
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < out_idle_pct) begin
            stall_left  <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            rot_check.check_rotated(out_beat);
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3, 4, 5: return t_coord'($urandom());
            default: return t_coord'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic t_coord rand_pivot();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return t_coord'($urandom());
            default: return t_coord'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // angle with random or sign-extended upper bits
    function automatic logic [CW-1:0] rand_angle();
        logic signed [ANG_W-1:0] a;
        case ($urandom_range(0, 9))
            0: a = '0;
            1: a = ANG_MAX;
            2: a = ANG_MIN;
            3: a = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            4, 5: begin
                a = ANG_HALF_PI * (16'sd1 <<< $urandom_range(0, 2))
                    + 16'(int'($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1)) a = -a;
            end
            default: a = ANG_W'($urandom());
        endcase
        if ($urandom_range(0, 1))
            return {16'($urandom()), a};
        return {{(CW - ANG_W){a[ANG_W-1]}}, a};
    endfunction

    function automatic t_vertex rand_vertex();
        return {rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord()};
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        rot_check.write_reg(idx, data);
    endtask

    task automatic release_cfg();
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_vertex(input t_vertex v);
        int gap;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_pos_x, i_pos_y, i_pos_z, i_norm_x, i_norm_y, i_norm_z} <= v;
        do @(posedge i_clk); while (o_in_stall);
        rot_check.note_vertex(v);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (rot_check.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_config();
        int k;
        for (k = 0; k < 6; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                if (all_regs[k] <= erap_pkg::IDX_ANG_Z) write_reg(all_regs[k], rand_angle());
                else write_reg(all_regs[k], rand_pivot());
            end
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom());
        release_cfg();
    endtask

    initial begin
        int ph, k;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= erap_pkg::IDX_ANG_X;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        {i_pos_x, i_pos_y, i_pos_z, i_norm_x, i_norm_y, i_norm_z} <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all angles zero after reset: pass-through
        send_vertex('0);
        send_vertex({COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN});
        send_vertex({COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX});
        drain();

        // unmapped indexes, junk upper angle bits, extreme pivots, z skipped
        write_reg(IDX_SPARE_LO, $urandom());
        write_reg(IDX_SPARE_HI, $urandom());
        write_reg(erap_pkg::IDX_ANG_X, {16'hA5A5, ANG_MAX});
        write_reg(erap_pkg::IDX_ANG_Y, {16'h0000, ANG_MIN});
        write_reg(erap_pkg::IDX_ANG_Z, '0);
        write_reg(erap_pkg::IDX_PIV_X, COORD_MAX);
        write_reg(erap_pkg::IDX_PIV_Y, COORD_MIN);
        write_reg(erap_pkg::IDX_PIV_Z, '0);
        release_cfg();
        send_vertex('0);
        send_vertex({6{COORD_MAX}});
        send_vertex({6{COORD_MIN}});
        send_vertex({COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN});
        send_vertex({COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX});
        send_vertex(rand_vertex());
        drain();

        write_reg(erap_pkg::IDX_ANG_X, ANG_HALF_PI);
        write_reg(erap_pkg::IDX_ANG_Y, -ANG_PI);
        write_reg(erap_pkg::IDX_ANG_Z, 16'sd1);
        write_reg(erap_pkg::IDX_PIV_X, rand_pivot());
        write_reg(erap_pkg::IDX_PIV_Y, rand_pivot());
        write_reg(erap_pkg::IDX_PIV_Z, rand_pivot());
        write_reg(IDX_SPARE_HI, $urandom());
        release_cfg();
        for (k = 0; k < 5; k++) send_vertex(rand_vertex());
        drain();

        write_reg(erap_pkg::IDX_ANG_X, '0);
        write_reg(erap_pkg::IDX_ANG_Y, ANG_TWO_PI);
        write_reg(erap_pkg::IDX_ANG_Z, ANG_MIN);
        write_reg(erap_pkg::IDX_PIV_X, COORD_MIN);
        write_reg(erap_pkg::IDX_PIV_Y, COORD_MAX);
        write_reg(erap_pkg::IDX_PIV_Z, COORD_MAX);
        release_cfg();
        send_vertex({6{COORD_MAX}});
        send_vertex({6{COORD_MIN}});
        for (k = 0; k < 3; k++) send_vertex(rand_vertex());
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            random_config();
            if (ph == PHASES - 1) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 20 * $urandom_range(0, 2);
                out_idle_pct = 20 * $urandom_range(0, 2);
            end
            for (k = 0; k < PHASE_BEATS; k++) send_vertex(rand_vertex());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rot_check.mismatches == 0 && rot_check.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: euler_rotation_about_pivot_core.f
+incdir+sv
sv/erap_pkg.sv
sv/erap_trig.sv
sv/erap_axis.sv
sv/euler_rotation_about_pivot_core.sv
sv/erap_checker.sv
tb/sv/euler_rotation_about_pivot_core_tb.sv
